/* rtl/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies; imported by rmq_front, rmq_queue, rmq_back and the top level.
package rmq_pkg;

    // Component that comes straight from the square root (the largest one).
    typedef enum logic [1:0] {
        BR_X = 2'd0,
        BR_Y = 2'd1,
        BR_Z = 2'd2,
        BR_W = 2'd3
    } t_branch;

    // Entries of the queue between the classifier and the arithmetic pipeline.
    localparam int QUEUE_DEPTH = 2;

    // Occupancy flags of the decoupling queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

/* rtl/rmq_mat_if.sv */
// Input channel carrying one 3x3 matrix, row-major, signed fixed point.
// Depends on nothing; used by the top level and the classifier.
interface rmq_mat_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r0c0;
    logic signed [W-1:0] r0c1;
    logic signed [W-1:0] r0c2;
    logic signed [W-1:0] r1c0;
    logic signed [W-1:0] r1c1;
    logic signed [W-1:0] r1c2;
    logic signed [W-1:0] r2c0;
    logic signed [W-1:0] r2c1;
    logic signed [W-1:0] r2c2;

    modport source (output valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                    input ready);
    modport sink (input valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                  output ready);
endinterface

/* rtl/rmq_quat_if.sv */
// Output channel carrying one quaternion and the degenerate flag.
// Depends on nothing; used by the top level and the back end.
interface rmq_quat_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;
    logic signed [W-1:0] quat_w;
    logic                degenerate;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, degenerate, output ready);
endinterface

/* rtl/rmq_front.sv */
// Classifier: picks the branch from trace and diagonal, forms the radicand
// and the three numerators. Depends on rmq_pkg and rmq_mat_if.
module rmq_front #(
    parameter int W    = 32,
    parameter int F    = 30,
    parameter int RADU = 34
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rmq_mat_if.sink                       i_mat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2+RADU+3*(W+1)-1:0]     o_data
);
    import rmq_pkg::*;

    localparam int RADW = RADU + 1;
    localparam int PW   = 2 + RADU + 3 * (W + 1);
    localparam logic signed [RADW-1:0] ONE_FX = RADW'(1) << F;

    logic signed [W+1:0]   trace;
    logic signed [RADW-1:0] e0, e4, e8, rad_s;
    logic [RADU-1:0]       rad_u;
    logic signed [W:0]     na, nb, nc;
    t_branch               branch;
    logic                  r_valid;
    logic [PW-1:0]         r_data;

    // Trace and sign-extended diagonal.
    assign trace = (W+2)'(i_mat.r0c0) + (W+2)'(i_mat.r1c1) + (W+2)'(i_mat.r2c2);
    assign e0    = RADW'(i_mat.r0c0);
    assign e4    = RADW'(i_mat.r1c1);
    assign e8    = RADW'(i_mat.r2c2);

    // Branch choice; the three numerators are kept in component order,
    // skipping the component that the root gives directly.
    always_comb begin
        if (trace > 0) begin
            branch = BR_W;
            rad_s  = e0 + e4 + e8 + ONE_FX;
            na     = (W+1)'(i_mat.r2c1) - (W+1)'(i_mat.r1c2);
            nb     = (W+1)'(i_mat.r0c2) - (W+1)'(i_mat.r2c0);
            nc     = (W+1)'(i_mat.r1c0) - (W+1)'(i_mat.r0c1);
        end else if (i_mat.r0c0 > i_mat.r1c1 && i_mat.r0c0 > i_mat.r2c2) begin
            branch = BR_X;
            rad_s  = ONE_FX + e0 - e4 - e8;
            na     = (W+1)'(i_mat.r0c1) + (W+1)'(i_mat.r1c0);
            nb     = (W+1)'(i_mat.r0c2) + (W+1)'(i_mat.r2c0);
            nc     = (W+1)'(i_mat.r2c1) - (W+1)'(i_mat.r1c2);
        end else if (i_mat.r1c1 > i_mat.r2c2) begin
            branch = BR_Y;
            rad_s  = ONE_FX + e4 - e0 - e8;
            na     = (W+1)'(i_mat.r0c1) + (W+1)'(i_mat.r1c0);
            nb     = (W+1)'(i_mat.r1c2) + (W+1)'(i_mat.r2c1);
            nc     = (W+1)'(i_mat.r0c2) - (W+1)'(i_mat.r2c0);
        end else begin
            branch = BR_Z;
            rad_s  = ONE_FX + e8 - e0 - e4;
            na     = (W+1)'(i_mat.r0c2) + (W+1)'(i_mat.r2c0);
            nb     = (W+1)'(i_mat.r1c2) + (W+1)'(i_mat.r2c1);
            nc     = (W+1)'(i_mat.r1c0) - (W+1)'(i_mat.r0c1);
        end
    end

    // A negative radicand is clamped to zero.
    assign rad_u = rad_s[RADW-1] ? '0 : rad_s[RADU-1:0];

    // Output register; a new matrix is taken whenever it is empty or drains.
    assign i_mat.ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_mat.ready) begin
            r_valid <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mat.ready) begin
            r_data <= {branch, rad_u, na, nb, nc};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* rtl/rmq_queue.sv */
// Short queue that decouples the classifier from the arithmetic pipeline.
// Depends on rmq_pkg for its depth and status type.
module rmq_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);
    import rmq_pkg::*;

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0]   r_mem [QUEUE_DEPTH];
    logic [PTRW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0] r_count;
    t_queue_status   status;
    logic            push, pop;

    assign status.full  = (r_count == CNTW'(QUEUE_DEPTH));
    assign status.empty = (r_count == '0);
    assign o_ready      = !status.full;
    assign o_valid      = !status.empty;
    assign push         = i_valid && o_ready;
    assign pop          = o_valid && i_ready;
    assign o_data       = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");
    a_full_no_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.full && !pop |=> status.full && $stable(r_wr_ptr))
        else $error("queue accepted a transfer while full");
endmodule

/* rtl/rmq_sqrt.sv */
// Pipelined integer square root of (radicand << F), one root bit per stage.
// Carries an opaque payload alongside. Depends on nothing.
module rmq_sqrt #(
    parameter int RADU = 34,
    parameter int F    = 30,
    parameter int PW   = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [RADU-1:0]                         i_rad,
    input  logic [PW-1:0]                           i_pay,
    output logic                                    o_valid,
    output logic [(RADU+F+((RADU+F)%2))/2-1:0]      o_root,
    output logic [PW-1:0]                           o_pay
);
    localparam int OPW = RADU + F;
    localparam int SQW = OPW + (OPW % 2);
    localparam int RTW = SQW / 2;

    logic            r_v    [RTW];
    logic [RADU-1:0] r_rad  [RTW];
    logic [RTW+1:0]  r_rem  [RTW];
    logic [RTW-1:0]  r_root [RTW];
    logic [PW-1:0]   r_pay  [RTW];

    // Each stage brings down one bit pair of the operand and decides one root bit.
    for (genvar s = 0; s < RTW; s++) begin : g_stage
        localparam int K = RTW - 1 - s;

        logic            v_in;
        logic [RADU-1:0] rad_in;
        logic [RTW+1:0]  rem_in;
        logic [RTW-1:0]  root_in;
        logic [PW-1:0]   pay_in;
        logic            b1, b0, take;
        logic [RTW+3:0]  rem_sh, trial, diff;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign pay_in  = i_pay;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign rad_in  = r_rad[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign pay_in  = r_pay[s-1];
        end

        // Operand bits below F are the zeros of the scaling shift.
        if (2*K+1 >= F && 2*K+1-F < RADU) begin : g_b1
            assign b1 = rad_in[2*K+1-F];
        end else begin : g_b1_zero
            assign b1 = 1'b0;
        end
        if (2*K >= F && 2*K-F < RADU) begin : g_b0
            assign b0 = rad_in[2*K-F];
        end else begin : g_b0_zero
            assign b0 = 1'b0;
        end

        assign rem_sh = {rem_in, b1, b0};
        assign trial  = {2'b00, root_in, 2'b01};
        assign take   = (rem_sh >= trial);
        assign diff   = rem_sh - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s]  <= rad_in;
                r_rem[s]  <= take ? diff[RTW+1:0] : rem_sh[RTW+1:0];
                r_root[s] <= {root_in[RTW-2:0], take};
                r_pay[s]  <= pay_in;
            end
        end
    end

    assign o_valid = r_v[RTW-1];
    assign o_root  = r_root[RTW-1];
    assign o_pay   = r_pay[RTW-1];
endmodule

/* rtl/rmq_div.sv */
// Pipelined fixed-point divider: three numerators over one shared divisor,
// one quotient bit per stage after the first, with overflow detection. Depends on nothing.
module rmq_div #(
    parameter int W  = 32,
    parameter int F  = 30,
    parameter int DW = 33,
    parameter int PW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DW-1:0]        i_den,
    input  logic [2:0][W:0]      i_num,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_valid,
    output logic [2:0][W-1:0]    o_q,
    output logic [2:0]           o_ovf,
    output logic [2:0]           o_neg,
    output logic [PW-1:0]        o_pay
);
    localparam int NL = 3;
    localparam int NW = W + 1 + F;
    localparam int CW = (F + 1 > DW) ? F + 1 : DW;
    localparam int NS = W + 1;

    logic          r_v   [NS];
    logic [DW-1:0] r_den [NS];
    logic [PW-1:0] r_pay [NS];
    logic [DW-1:0] r_rem [NS][NL];
    logic [W-1:0]  r_low [NS][NL];
    logic [W-1:0]  r_q   [NS][NL];
    logic          r_neg [NS][NL];
    logic          r_ovf [NS][NL];

    // Control and divisor carried through every stage.
    for (genvar s = 0; s < NS; s++) begin : g_ctl
        logic          v_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] pay_in;

        if (s == 0) begin : g_first
            assign v_in   = i_valid;
            assign den_in = i_den;
            assign pay_in = i_pay;
        end else begin : g_next
            assign v_in   = r_v[s-1];
            assign den_in = r_den[s-1];
            assign pay_in = r_pay[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= den_in;
                r_pay[s] <= pay_in;
            end
        end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
        logic          neg;
        logic [W:0]    mag;
        logic [NW-1:0] dividend;
        logic [CW-1:0] top_c;
        logic          ovf;

        // Magnitude, scaled dividend and the check for a quotient of 2^W or more.
        assign neg      = i_num[l][W];
        assign mag      = neg ? (~i_num[l] + 1'b1) : i_num[l];
        assign dividend = {mag, {F{1'b0}}};
        assign top_c    = CW'(dividend[NW-1:W]);
        assign ovf      = (top_c >= CW'(i_den));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[0][l] <= neg;
                r_ovf[0][l] <= ovf;
                r_rem[0][l] <= ovf ? '0 : DW'(top_c);
                r_low[0][l] <= dividend[W-1:0];
                r_q[0][l]   <= '0;
            end
        end

        // Long division: one dividend bit shifted in and one quotient bit per stage.
        for (genvar s = 1; s < NS; s++) begin : g_step
            localparam int J = W - s;

            logic [DW:0]   rem_sh, diff;
            logic          take;
            logic [W-1:0]  q_n;

            assign rem_sh = {r_rem[s-1][l], r_low[s-1][l][J]};
            assign take   = (rem_sh >= {1'b0, r_den[s-1]});
            assign diff   = rem_sh - {1'b0, r_den[s-1]};

            always_comb begin
                q_n    = r_q[s-1][l];
                q_n[J] = take;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_neg[s][l] <= r_neg[s-1][l];
                    r_ovf[s][l] <= r_ovf[s-1][l];
                    r_rem[s][l] <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
                    r_low[s][l] <= r_low[s-1][l];
                    r_q[s][l]   <= q_n;
                end
            end
        end

        assign o_q[l]   = r_q[NS-1][l];
        assign o_ovf[l] = r_ovf[NS-1][l];
        assign o_neg[l] = r_neg[NS-1][l];
    end

    assign o_valid = r_v[NS-1];
    assign o_pay   = r_pay[NS-1];
endmodule

/* rtl/rmq_back.sv */
// Back end: square root, three divisions and the saturating output register.
// Depends on rmq_pkg, rmq_quat_if, rmq_sqrt and rmq_div.
module rmq_back #(
    parameter int W    = 32,
    parameter int F    = 30,
    parameter int RADU = 34
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2+RADU+3*(W+1)-1:0]     i_data,
    rmq_quat_if.source                    o_quat
);
    import rmq_pkg::*;

    localparam int OPW  = RADU + F;
    localparam int SQW  = OPW + (OPW % 2);
    localparam int RTW  = SQW / 2;
    localparam int DW   = RTW + 1;
    localparam int SPW  = 2 + 3 * (W + 1);
    localparam int DPW  = 2 + RTW;
    localparam int BW   = (RTW > W) ? RTW : W;
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] HALF   = {1'b1, {(W-1){1'b0}}};

    logic               en;
    logic [RADU-1:0]    rad;
    logic [SPW-1:0]     s_pay_in, s_pay_out;
    logic               s_valid;
    logic [RTW-1:0]     s_root;
    logic [2:0][W:0]    nums;
    logic               d_valid;
    logic [2:0][W-1:0]  d_q;
    logic [2:0]         d_ovf, d_neg;
    logic [DPW-1:0]     d_pay;
    t_branch            branch;
    logic [RTW-1:0]     root;
    logic [W-1:0]       big, l0, l1, l2;
    logic [W-1:0]       n_x, n_y, n_z, n_w;
    logic               n_deg;
    logic               r_valid, r_deg;
    logic [W-1:0]       r_x, r_y, r_z, r_w;

    // Signed, saturated word from sign, overflow flag and quotient magnitude.
    function automatic logic [W-1:0] to_word(input logic neg, input logic ovf,
                                              input logic [W-1:0] q);
        logic sat;
        sat = ovf || (q > HALF);
        if (neg) begin
            to_word = sat ? HALF : (~q + 1'b1);
        end else begin
            to_word = (sat || q >= HALF) ? MAXPOS : q;
        end
    endfunction

    // The whole pipeline advances unless a finished result is waiting and not taken.
    assign en      = !r_valid || o_quat.ready;
    assign o_ready = en;

    assign rad      = i_data[3*(W+1) +: RADU];
    assign s_pay_in = {i_data[2+RADU+3*(W+1)-1 -: 2], i_data[3*(W+1)-1:0]};

    rmq_sqrt #(.RADU(RADU), .F(F), .PW(SPW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_rad   (rad),
        .i_pay   (s_pay_in),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_pay   (s_pay_out)
    );

    assign nums[0] = s_pay_out[3*(W+1)-1 -: W+1];
    assign nums[1] = s_pay_out[2*(W+1)-1 -: W+1];
    assign nums[2] = s_pay_out[W:0];

    rmq_div #(.W(W), .F(F), .DW(DW), .PW(DPW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_den   ({s_root, 1'b0}),
        .i_num   (nums),
        .i_pay   ({s_pay_out[SPW-1 -: 2], s_root}),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_ovf   (d_ovf),
        .o_neg   (d_neg),
        .o_pay   (d_pay)
    );

    assign branch = t_branch'(d_pay[DPW-1 -: 2]);
    assign root   = d_pay[RTW-1:0];

    // Component from the root itself, then the three quotients.
    always_comb begin
        if (BW'(root[RTW-1:1]) > BW'(MAXPOS)) begin
            big = MAXPOS;
        end else begin
            big = W'(root[RTW-1:1]);
        end
    end

    assign l0 = to_word(d_neg[0], d_ovf[0], d_q[0]);
    assign l1 = to_word(d_neg[1], d_ovf[1], d_q[1]);
    assign l2 = to_word(d_neg[2], d_ovf[2], d_q[2]);

    // Put the components in place; a zero root forces zeros and the flag.
    always_comb begin
        n_deg = (root == '0);
        case (branch)
            BR_X: begin
                n_x = big; n_y = l0;  n_z = l1;  n_w = l2;
            end
            BR_Y: begin
                n_x = l0;  n_y = big; n_z = l1;  n_w = l2;
            end
            BR_Z: begin
                n_x = l0;  n_y = l1;  n_z = big; n_w = l2;
            end
            default: begin
                n_x = l0;  n_y = l1;  n_z = l2;  n_w = big;
            end
        endcase
        if (n_deg) begin
            n_x = '0;
            n_y = '0;
            n_z = '0;
            n_w = '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_w   <= n_w;
            r_deg <= n_deg;
        end
    end

    assign o_quat.valid      = r_valid;
    assign o_quat.quat_x     = r_x;
    assign o_quat.quat_y     = r_y;
    assign o_quat.quat_z     = r_z;
    assign o_quat.quat_w     = r_w;
    assign o_quat.degenerate = r_deg;

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_deg |-> r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0)
        else $error("degenerate result with nonzero components");
    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_quat.ready |-> !o_ready)
        else $error("pipeline took a transfer while the output stalled");
endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
// Depends on rmq_pkg, both channel interfaces, rmq_front, rmq_queue and rmq_back.
//
//   Port      Direction  Contents
//   i_mat     in         nine matrix entries r0c0..r2c2, signed fixed point
//   o_quat    out        quat_x, quat_y, quat_z, quat_w, degenerate
//
// One matrix is accepted per cycle in steady state while the output is not stalled.
// A matrix passes the classifier register, the queue, the square root pipeline, the
// divider pipeline and the output register in that order.
// Reset is synchronous and active low; it clears valid bits, queue pointers and queue count only.
// A stalled output freezes the arithmetic pipeline; the queue keeps absorbing up to two
// matrices from the classifier, whose register holds one more, before input ready drops.
module rotation_matrix_to_quaternion #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmq_mat_if.sink     i_mat,
    rmq_quat_if.source  o_quat
);
    import rmq_pkg::*;

    localparam int RADU = ((WORD_WIDTH > FRAC_BITS) ? WORD_WIDTH : FRAC_BITS) + 2;
    localparam int PW   = 2 + RADU + 3 * (WORD_WIDTH + 1);

    logic          f_valid, f_ready;
    logic [PW-1:0] f_data;
    logic          q_valid, q_ready;
    logic [PW-1:0] q_data;

    rmq_front #(.W(WORD_WIDTH), .F(FRAC_BITS), .RADU(RADU)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (i_mat),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    rmq_queue #(.DW(PW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    rmq_back #(.W(WORD_WIDTH), .F(FRAC_BITS), .RADU(RADU)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_data  (q_data),
        .o_quat  (o_quat)
    );
endmodule
